// ===== rtl/non_max_suppression_iou_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the greedy box suppression block
// Shared property forms, clocked on clk and held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef NON_MAX_SUPPRESSION_IOU_DEFINES_SVH
`define NON_MAX_SUPPRESSION_IOU_DEFINES_SVH

// consequent holds in the same cycle
`define NMSI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the next cycle
`define NMSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/nmsi_pkg.sv =====
// ----------------------------------------------------------------------------
// nmsi_pkg
// Types and constants shared by the box suppression block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nmsi_pkg;

  localparam int MAX_BOXES_DEF = 64;
  localparam int RESULT_CAP    = 64;
  localparam int ONE_PIXEL     = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [1:0] CFG_CONF_THR   = 2'd0;
  localparam logic [1:0] CFG_IOU_THR    = 2'd1;
  localparam logic [1:0] CFG_CORNER_FMT = 2'd2;

  typedef struct packed {
    logic signed [15:0] coord_a;
    logic signed [15:0] coord_b;
    logic signed [15:0] coord_c;
    logic signed [15:0] coord_d;
    logic        [15:0] confidence;
    logic               last_box;
  } box_t;

  typedef struct packed {
    logic [5:0] kept_index;
    logic       none_kept;
    logic       overflowed;
    logic       last_result;
  } result_t;

  typedef struct packed {
    logic [63:0] coords;
    logic [15:0] score;
    logic        live;
    logic        last;
  } q_item_t;

endpackage

// ===== rtl/non_max_suppression_iou.sv =====
// ----------------------------------------------------------------------------
// non_max_suppression_iou
// Greedy non-maximum suppression of scored boxes by IoU threshold.
//
// Boxes enter on push/full, one per cycle while full is low; last_box ends
// a set. A four-deep queue sits ahead of the engine, so up to four boxes
// can load while a previous set is still being suppressed.
// After the last box of a set the engine makes one pick after another:
// each pick is one scan of the score memory and one IoU pass through a
// six-stage pipeline, both limited to one memory read per cycle.
// Results leave on empty/pop from a one-beat output register; a stall on
// pop holds the engine, and the input queue then fills and raises full.
// Configuration writes on cfg_valid/cfg_ready are always ready and take
// effect at once; change them only while the block is idle.
// Reset empties the queue, clears the set and restores the thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module non_max_suppression_iou
  import nmsi_pkg::*;
#(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  box_t        box,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] conf_threshold;
  logic [15:0] iou_threshold;
  logic        corner_format;
  logic        q_valid;
  q_item_t     q_head;
  logic        q_pop;
  logic        out_push;
  result_t     out_data;
  logic        out_ready;
  logic        out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;
  assign out_ready = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_threshold <= 16'd13107;
      iou_threshold  <= 16'd13107;
      corner_format  <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CONF_THR:   conf_threshold <= cfg_data;
        CFG_IOU_THR:    iou_threshold  <= cfg_data;
        CFG_CORNER_FMT: corner_format  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= out_push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && out_push) result <= out_data;
  end

  nmsi_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .box            (box),
    .conf_threshold (conf_threshold),
    .q_valid        (q_valid),
    .q_head         (q_head),
    .q_pop          (q_pop)
  );

  nmsi_back #(
    .MAX_BOXES (MAX_BOXES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .iou_threshold (iou_threshold),
    .corner_format (corner_format),
    .out_push      (out_push),
    .out_data      (out_data),
    .out_ready     (out_ready)
  );

endmodule

// ===== rtl/nmsi_front.sv =====
// ----------------------------------------------------------------------------
// nmsi_front
// Accepts boxes, marks each live against the confidence threshold and
// holds them in a short queue for the suppression engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmsi_front
  import nmsi_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  box_t        box,
  input  logic [15:0] conf_threshold,
  output logic        q_valid,
  output q_item_t     q_head,
  input  logic        q_pop
);

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t            q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [FILL_W-1:0]  fill;
  logic               do_push;
  logic               do_pop;

  assign full    = (fill == FILL_W'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_head  = q[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{coords: {box.coord_d, box.coord_c, box.coord_b, box.coord_a},
                     score:  box.confidence,
                     live:   box.confidence >= conf_threshold,
                     last:   box.last_box};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop)      fill <= fill + 1'b1;
      else if (!do_push && do_pop) fill <= fill - 1'b1;
    end
  end

endmodule

// ===== rtl/nmsi_back.sv =====
// ----------------------------------------------------------------------------
// nmsi_back
// Stores the boxes of a set, then picks the best live box, emits it and
// runs a pipelined IoU pass that drops the boxes it overlaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmsi_back
  import nmsi_pkg::*;
#(
  parameter int MAX_BOXES = MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  q_item_t     q_head,
  output logic        q_pop,
  input  logic [15:0] iou_threshold,
  input  logic        corner_format,
  output logic        out_push,
  output result_t     out_data,
  input  logic        out_ready
);

  localparam int IDX_W  = $clog2(MAX_BOXES);
  localparam int CNT_W  = $clog2(MAX_BOXES + 1);
  localparam int PICK_W = $clog2(RESULT_CAP + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SCAN   = 3'd1;
  localparam logic [2:0] ST_EMIT   = 3'd2;
  localparam logic [2:0] ST_SUPP   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  typedef struct packed {
    logic signed [17:0] x1;
    logic signed [17:0] y1;
    logic signed [17:0] x2;
    logic signed [17:0] y2;
  } corner_t;

  function automatic corner_t to_corners(input logic [63:0] p, input logic cf);
    logic signed [17:0] a, b, c, d;
    corner_t r;
    a = 18'($signed(p[15:0]));
    b = 18'($signed(p[31:16]));
    c = 18'($signed(p[47:32]));
    d = 18'($signed(p[63:48]));
    if (cf) begin
      r.x1 = a <<< 1; r.y1 = b <<< 1; r.x2 = c <<< 1; r.y2 = d <<< 1;
    end else begin
      r.x1 = (a <<< 1) - c; r.x2 = (a <<< 1) + c;
      r.y1 = (b <<< 1) - d; r.y2 = (b <<< 1) + d;
    end
    return r;
  endfunction

  logic [63:0] coord_mem [MAX_BOXES];
  logic [15:0] score_mem [MAX_BOXES];
  logic [MAX_BOXES-1:0] live;

  logic [2:0]        state;
  logic [CNT_W-1:0]  count;
  logic              ovf;
  logic [CNT_W-1:0]  ptr;
  logic [IDX_W-1:0]  rd_addr;
  logic [63:0]       rd_coord;
  logic [15:0]       rd_score;
  logic              issue;

  logic              found;
  logic [IDX_W-1:0]  best;
  logic [63:0]       best_coord;
  logic [15:0]       best_score;
  logic              pend_v;
  logic [IDX_W-1:0]  pend_idx;
  logic [PICK_W-1:0] picks;

  // read stage and IoU pipeline
  logic              s0_v;
  logic [IDX_W-1:0]  s0_idx;
  logic              p1_v, p2_v, p3_v, p4_v, p5_v;
  logic [IDX_W-1:0]  p1_idx, p2_idx, p3_idx, p4_idx, p5_idx;
  logic              p1_eq, p2_eq, p3_eq, p4_eq, p5_eq;
  corner_t           p1_c;
  logic signed [18:0] p2_iw, p2_ih, p2_wa, p2_ha, p2_wb, p2_hb;
  logic signed [37:0] p3_inter, p3_area_a, p3_area_b;
  logic signed [39:0] p4_uni;
  logic signed [37:0] p4_inter;
  logic signed [56:0] p5_lhs, p5_rhs;
  logic              p5_uni_pos, p5_uni_zero, p5_inter_zero;
  logic              p5_drop;

  corner_t            bc;
  corner_t            cc;
  logic signed [18:0] iw_raw, ih_raw;
  logic               pipe_busy;

  assign bc = to_corners(best_coord, corner_format);
  assign cc = p1_c;
  assign issue = (ptr < count) && ((state == ST_SCAN) || (state == ST_SUPP));
  assign rd_addr = ptr[IDX_W-1:0];
  assign q_pop = (state == ST_IDLE) && q_valid;
  assign pipe_busy = s0_v || p1_v || p2_v || p3_v || p4_v || p5_v;

  assign iw_raw = 19'((cc.x2 < bc.x2) ? cc.x2 : bc.x2) - 19'((cc.x1 > bc.x1) ? cc.x1 : bc.x1)
                  + 19'(ONE_PIXEL);
  assign ih_raw = 19'((cc.y2 < bc.y2) ? cc.y2 : bc.y2) - 19'((cc.y1 > bc.y1) ? cc.y1 : bc.y1)
                  + 19'(ONE_PIXEL);

  assign p5_drop = p5_eq || (p5_uni_pos ? (p5_lhs >= p5_rhs) :
                             p5_uni_zero ? 1'b1 :
                             (p5_inter_zero && (iou_threshold == '0)));

  always_ff @(posedge clk) begin
    if (q_pop && (count < CNT_W'(MAX_BOXES))) begin
      coord_mem[count[IDX_W-1:0]] <= q_head.coords;
      score_mem[count[IDX_W-1:0]] <= q_head.score;
    end
    rd_coord <= coord_mem[rd_addr];
    rd_score <= score_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    p1_c   <= to_corners(rd_coord, corner_format);
    p1_eq  <= (rd_coord == best_coord) && (rd_score == best_score);
    p1_idx <= s0_idx;
    p2_iw  <= iw_raw[18] ? '0 : iw_raw;
    p2_ih  <= ih_raw[18] ? '0 : ih_raw;
    p2_wa  <= 19'(bc.x2) - 19'(bc.x1) + 19'(ONE_PIXEL);
    p2_ha  <= 19'(bc.y2) - 19'(bc.y1) + 19'(ONE_PIXEL);
    p2_wb  <= 19'(cc.x2) - 19'(cc.x1) + 19'(ONE_PIXEL);
    p2_hb  <= 19'(cc.y2) - 19'(cc.y1) + 19'(ONE_PIXEL);
    p2_eq  <= p1_eq;
    p2_idx <= p1_idx;
    p3_inter  <= p2_iw * p2_ih;
    p3_area_a <= p2_wa * p2_ha;
    p3_area_b <= p2_wb * p2_hb;
    p3_eq     <= p2_eq;
    p3_idx    <= p2_idx;
    p4_uni    <= 40'(p3_area_a) + 40'(p3_area_b) - 40'(p3_inter);
    p4_inter  <= p3_inter;
    p4_eq     <= p3_eq;
    p4_idx    <= p3_idx;
    p5_lhs        <= 57'(p4_inter) <<< 16;
    p5_rhs        <= $signed({1'b0, iou_threshold}) * p4_uni;
    p5_uni_pos    <= (p4_uni > 0);
    p5_uni_zero   <= (p4_uni == 0);
    p5_inter_zero <= (p4_inter == 0);
    p5_eq         <= p4_eq;
    p5_idx        <= p4_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      ovf      <= 1'b0;
      ptr      <= '0;
      live     <= '0;
      found    <= 1'b0;
      best     <= '0;
      pend_v   <= 1'b0;
      pend_idx <= '0;
      picks    <= '0;
      s0_v     <= 1'b0;
      s0_idx   <= '0;
      p1_v     <= 1'b0;
      p2_v     <= 1'b0;
      p3_v     <= 1'b0;
      p4_v     <= 1'b0;
      p5_v     <= 1'b0;
    end else begin
      s0_v   <= issue && live[rd_addr];
      s0_idx <= rd_addr;
      p1_v   <= s0_v && (state == ST_SUPP);
      p2_v   <= p1_v;
      p3_v   <= p2_v;
      p4_v   <= p3_v;
      p5_v   <= p4_v;
      if (issue) ptr <= ptr + 1'b1;
      unique case (state)
        ST_IDLE: begin
          if (q_pop) begin
            if (count < CNT_W'(MAX_BOXES)) begin
              live[count[IDX_W-1:0]] <= q_head.live;
              count <= count + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (q_head.last) begin
              ptr   <= '0;
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (s0_v && (!found || (rd_score > best_score))) begin
            found      <= 1'b1;
            best       <= s0_idx;
            best_coord <= rd_coord;
            best_score <= rd_score;
          end
          if (!issue && !s0_v) begin
            ptr   <= '0;
            state <= found ? ST_EMIT : ST_FINISH;
          end
        end
        ST_EMIT: begin
          if (!pend_v || out_ready) begin
            pend_v   <= 1'b1;
            pend_idx <= best;
            picks    <= picks + 1'b1;
            found    <= 1'b0;
            ptr      <= '0;
            state    <= (picks + 1'b1 == PICK_W'(RESULT_CAP)) ? ST_FINISH : ST_SUPP;
          end
        end
        ST_SUPP: begin
          if (p5_v && p5_drop) live[p5_idx] <= 1'b0;
          if (!issue && !pipe_busy) begin
            ptr   <= '0;
            state <= ST_SCAN;
          end
        end
        ST_FINISH: begin
          if (out_ready) begin
            count  <= '0;
            ovf    <= 1'b0;
            pend_v <= 1'b0;
            picks  <= '0;
            found  <= 1'b0;
            ptr    <= '0;
            state  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    out_push = 1'b0;
    out_data = '0;
    if ((state == ST_EMIT) && pend_v && out_ready) begin
      out_push = 1'b1;
      out_data = '{kept_index: 6'(pend_idx), none_kept: 1'b0,
                   overflowed: ovf, last_result: 1'b0};
    end else if ((state == ST_FINISH) && out_ready) begin
      out_push = 1'b1;
      out_data = '{kept_index: pend_v ? 6'(pend_idx) : 6'd0, none_kept: !pend_v,
                   overflowed: ovf, last_result: 1'b1};
    end
  end

endmodule

// ===== rtl/nmsi_checker.sv =====
// ----------------------------------------------------------------------------
// nmsi_checker
// Port-level checks on the result channel of the suppression block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "non_max_suppression_iou_defines.svh"

module nmsi_checker
  import nmsi_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  `NMSI_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(result), "result beat dropped while stalled")
  `NMSI_ASSERT_NOW(a_none_last, !empty && result.none_kept, result.last_result, "none result not last")
  `NMSI_ASSERT_NOW(a_none_idx, !empty && result.none_kept, result.kept_index == 6'd0, "none result index")

endmodule

bind non_max_suppression_iou nmsi_checker u_chk (.*);
